@@ rtl/bbr_pkg.sv @@
// Shared constants, config struct and a coordinate function for the reflect-101 box blur.
package bbr_pkg;
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxKernel = 7;
  localparam int unsigned MaxHeight    = 1024;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 11;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKernelSize  = 2'd2;

  localparam logic KindPixel = 1'b0;
  localparam logic KindDrain = 1'b1;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [2:0]  kernel_size;
  } cfg_t;

  // Reflect-101 of a signed coordinate, clamped into 0..size-1.
  function automatic logic [12:0] reflect101(input logic signed [13:0] n,
                                             input logic [11:0] size);
    logic signed [14:0] m;
    logic signed [14:0] s;
    s = $signed({3'b000, size});
    m = {n[13], n};
    if (m < 0) m = -m;
    else if (m >= s) m = 15'(2 * s - m - 15'sd2);
    if (m < 0) m = '0;
    if (m > s - 15'sd1) m = s - 15'sd1;
    return m[12:0];
  endfunction
endpackage

@@ rtl/bbr_if.sv @@
// Valid/ready stream interfaces for pixel, result and config channels.
interface bbr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] pixel;
  modport source (output valid, kind, pixel, input ready);
  modport sink   (input valid, kind, pixel, output ready);
endinterface

interface bbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blurred;
  logic       frame_end;
  modport source (output valid, blurred, frame_end, input ready);
  modport sink   (input valid, blurred, frame_end, output ready);
endinterface

interface bbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bbr_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module bbr_divider import bbr_pkg::*; #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quot_d = quot_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i; rem_d = '0; cnt_d = CntW'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d; rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end
  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

@@ rtl/box_blur_reflect101.sv @@
// Top level of the streaming k by k box blur with reflect-101 borders.
// Pixels come in raster order; output (y,x) leaves when input (y+k/2+1,x)
// arrives, and drain ticks flush the last rows once the frame is in. Each
// pixel is written to a line store of 8 rows. An item that yields a result
// walks its k*k window through one memory read port, one stored pixel per
// cycle, into a single accumulator, then a one-bit-per-cycle divider forms
// the rounded mean, which waits in StOut while the output register is full.
// Items that give no result go back to idle after StDecide. The block is not
// ready while one item is in work.
// The line store holds no reset; reading rows never written is undefined.
module box_blur_reflect101 import bbr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_KERNEL = DefMaxKernel
) (
  input logic         clk_i,
  input logic         rst_ni,
  bbr_cfg_if.sink     cfg,
  bbr_in_if.sink      pix_in,
  bbr_out_if.source   pix_out
);
  // ring of rows, a power of two of at least k+1 rows
  localparam int unsigned Slots = 1 << $clog2((MAX_KERNEL | 1) + 1);
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned AddrW = SlotW + ColW;
  localparam int unsigned KW    = $clog2(MAX_KERNEL + 1);
  localparam int unsigned SumW  = 8 + 2 * KW;
  localparam int unsigned NumW  = SumW + 2;
  localparam int unsigned DenW  = 2 * KW + 1;

  typedef enum logic [2:0] {
    StIdle, StDecide, StRead, StTail, StDiv, StOut
  } state_e;

  state_e          state_q;
  cfg_t            cfg_q;
  logic [12:0]     in_col_q, in_row_q, out_col_q, out_row_q;
  logic [KW-1:0]   dy_q, dx_q;
  logic            kind_q;
  logic [7:0]      pix_q;
  logic [SumW-1:0] sum_q;
  logic [1:0]      tail_q;
  logic            last_q;
  logic [7:0]      blur_q;
  logic            ovalid_q;
  logic [7:0]      mem [2**AddrW];
  logic [7:0]      rd_q;
  logic            rd_vld_q;

  // effective config
  logic [11:0] w, h;
  logic [KW-1:0] k, half;
  always_comb begin
    w = (cfg_q.frame_width == 0) ? 12'd1 :
        (32'(cfg_q.frame_width) > MAX_WIDTH) ? 12'(MAX_WIDTH) :
        {1'b0, cfg_q.frame_width};
    h = (cfg_q.frame_height == 0) ? 12'd1 :
        ({1'b0, cfg_q.frame_height} > 12'(MaxHeight)) ? 12'(MaxHeight) :
        {1'b0, cfg_q.frame_height};
    k = (cfg_q.kernel_size == 0) ? KW'(1) :
        (32'(cfg_q.kernel_size) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(cfg_q.kernel_size);
    half = k >> 1;
  end

  assign cfg.ready = (state_q == StIdle);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{frame_width: 11'd64, frame_height: 11'd64, kernel_size: 3'd3};
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        RegFrameWidth:  cfg_q.frame_width  <= cfg.data;
        RegFrameHeight: cfg_q.frame_height <= cfg.data;
        RegKernelSize:  cfg_q.kernel_size  <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  assign pix_in.ready = (state_q == StIdle) && !cfg.valid;
  logic in_fire;
  assign in_fire = pix_in.valid && pix_in.ready;

  // window address of current tap
  logic [12:0] r_ref, c_ref, wr_col;
  logic [AddrW-1:0] rd_addr, wr_addr;
  always_comb begin
    r_ref = reflect101($signed({1'b0, out_row_q}) - $signed(14'(half))
                       + $signed(14'(dy_q)), h);
    c_ref = reflect101($signed({1'b0, out_col_q}) - $signed(14'(half))
                       + $signed(14'(dx_q)), w);
    rd_addr = {r_ref[SlotW-1:0], c_ref[ColW-1:0]};
    wr_col  = (in_col_q >= 13'(w)) ? 13'(w - 12'd1) : in_col_q;
    wr_addr = {in_row_q[SlotW-1:0], wr_col[ColW-1:0]};
  end

  logic mem_we, mem_re;
  assign mem_we = (state_q == StDecide) && (kind_q == KindPixel) && (in_row_q < 13'(h));
  assign mem_re = (state_q == StRead);
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= pix_q;
    if (mem_re) rd_q <= mem[rd_addr];
  end

  // pixel lands on the row that completes the pending window
  logic pix_hit;
  assign pix_hit = (in_row_q < 13'(h)) && (out_row_q < 13'(h))
                   && (out_row_q + 13'(half) + 13'd1 == in_row_q) && (out_col_q == wr_col);

  // divider
  logic [DenW-1:0] dd;
  logic [NumW-1:0] num, quot;
  logic div_start, div_done;
  assign dd  = DenW'(k * k);
  assign num = {sum_q, 1'b0} + NumW'(dd);
  assign div_start = (state_q == StTail) && (tail_q == 2'd0);
  bbr_divider #(.NumW(NumW), .DenW(DenW + 1)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num),
    .den_i({dd, 1'b0}), .done_o(div_done), .quot_o(quot)
  );

  logic emit_ok, last_c;
  assign last_c = (out_col_q + 13'd1 >= 13'(w)) && (out_row_q + 13'd1 >= 13'(h));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; in_col_q <= '0; in_row_q <= '0; out_col_q <= '0;
      out_row_q <= '0; ovalid_q <= 1'b0; rd_vld_q <= 1'b0; tail_q <= '0;
      dy_q <= '0; dx_q <= '0;
    end else begin
      rd_vld_q <= mem_re;
      if (emit_ok) ovalid_q <= 1'b1;
      else if (pix_out.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_fire) state_q <= StDecide;
        StDecide: begin
          dy_q <= '0; dx_q <= '0;
          if (kind_q == KindPixel) begin
            if (in_row_q < 13'(h)) begin
              if (in_col_q + 13'd1 >= 13'(w)) begin
                in_col_q <= '0; in_row_q <= in_row_q + 13'd1;
              end else in_col_q <= in_col_q + 13'd1;
            end
            state_q <= pix_hit ? StRead : StIdle;
          end else if (in_row_q >= 13'(h)) begin
            if (out_row_q >= 13'(h)) begin
              in_col_q <= '0; in_row_q <= '0; out_col_q <= '0; out_row_q <= '0;
              state_q <= StIdle;
            end else state_q <= StRead;
          end else state_q <= StIdle;
        end
        StRead: begin
          if (dx_q == k - 1'b1) begin
            dx_q <= '0;
            if (dy_q == k - 1'b1) begin
              state_q <= StTail; tail_q <= 2'd2;
            end else dy_q <= dy_q + 1'b1;
          end else dx_q <= dx_q + 1'b1;
        end
        StTail: if (tail_q == 2'd0) state_q <= StDiv; else tail_q <= tail_q - 2'd1;
        StDiv: if (div_done) state_q <= StOut;
        StOut: if (!ovalid_q || pix_out.ready) begin
          state_q <= StIdle;
          if (last_c) begin
            in_col_q <= '0; in_row_q <= '0; out_col_q <= '0; out_row_q <= '0;
          end else if (out_col_q + 13'd1 >= 13'(w)) begin
            out_col_q <= '0; out_row_q <= out_row_q + 13'd1;
          end else out_col_q <= out_col_q + 13'd1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign emit_ok = (state_q == StOut) && (!ovalid_q || pix_out.ready);
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= pix_in.kind; pix_q <= pix_in.pixel;
    end
    if (state_q == StDecide) sum_q <= '0;
    else if (rd_vld_q) sum_q <= sum_q + SumW'(rd_q);
    if (emit_ok) begin
      blur_q <= (quot > NumW'(255)) ? 8'd255 : quot[7:0];
      last_q <= last_c;
    end
  end

  assign pix_out.valid     = ovalid_q;
  assign pix_out.blurred   = blur_q;
  assign pix_out.frame_end = last_q;

`ifndef NO_ASSERTIONS
  a_not_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !pix_in.ready) else $error("ready while busy");
  a_no_read_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> !mem_we) else $error("read and write together");
  a_div_after_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == StDiv)) else $error("divider start lost");
`endif
endmodule
